FILE: sv/framebuffer_to_bmp_streamer_macros.svh
// assertion macros shared by the streamer rtl
`ifndef FRAMEBUFFER_TO_BMP_STREAMER_MACROS_SVH
`define FRAMEBUFFER_TO_BMP_STREAMER_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define FB2BMP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication, checked on clk, off during rst
`define FB2BMP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: sv/fb2bmp_pkg.sv
// types, constants and header table for the bmp streamer
`timescale 1ns / 1ps

package fb2bmp_pkg;

  localparam int STORE_BYTES_DEF = 32768;
  localparam int MAX_CHUNK_DEF   = 64;

  localparam logic [11:0] MAX_DIM      = 12'd2048;
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd384;

  localparam logic [15:0] BMP_MAGIC    = 16'h4D42;
  localparam logic [7:0]  HDR_BYTES    = 8'd62;
  localparam logic [7:0]  INFO_BYTES   = 8'd40;
  localparam logic [7:0]  PLANES       = 8'd1;
  localparam logic [7:0]  BIT_DEPTH    = 8'd1;
  localparam logic [7:0]  IMG_SIZE_TAG = 8'h23;
  localparam logic [7:0]  PAL_WHITE    = 8'hFF;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GEOM,
    S_SIZE,
    S_CLASS,
    S_DIV,
    S_BASE,
    S_STREAM
  } state_t;

  typedef enum logic [1:0] {
    MODE_EMPTY,
    MODE_HEADER,
    MODE_PIXEL
  } mode_t;

  typedef struct packed {
    logic [7:0] fixed_byte;
    logic       use_mem;
    logic       last;
    logic       empty;
  } stage_meta_t;

  function automatic logic [7:0] header_byte(input logic [5:0]  pos,
                                             input logic [11:0] w,
                                             input logic [11:0] h,
                                             input logic [19:0] fsize);
    logic [7:0] b;
    b = 8'h00;
    case (pos)
      6'd0:  b = BMP_MAGIC[7:0];
      6'd1:  b = BMP_MAGIC[15:8];
      6'd2:  b = fsize[7:0];
      6'd3:  b = fsize[15:8];
      6'd4:  b = {4'd0, fsize[19:16]};
      6'd10: b = HDR_BYTES;
      6'd14: b = INFO_BYTES;
      6'd18: b = w[7:0];
      6'd19: b = {4'd0, w[11:8]};
      6'd22: b = h[7:0];
      6'd23: b = {4'd0, h[11:8]};
      6'd26: b = PLANES;
      6'd28: b = BIT_DEPTH;
      6'd35: b = IMG_SIZE_TAG;
      6'd58: b = PAL_WHITE;
      6'd59: b = PAL_WHITE;
      6'd60: b = PAL_WHITE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/fb2bmp_ifs.sv
// channel interfaces: command items, file bytes, configuration writes
`timescale 1ns / 1ps

interface fb2bmp_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [14:0] store_address;
  logic [7:0]  store_data;
  logic [19:0] file_offset;
  logic [6:0]  chunk_length;

  modport source(output valid, command, store_address, store_data, file_offset,
                 chunk_length, input ready);
  modport sink(input valid, command, store_address, store_data, file_offset,
               chunk_length, output ready);
endinterface

interface fb2bmp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       last_of_chunk;
  logic       chunk_empty;

  modport source(output valid, file_byte, last_of_chunk, chunk_empty, input ready);
  modport sink(input valid, file_byte, last_of_chunk, chunk_empty, output ready);
endinterface

interface fb2bmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [11:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/framebuffer_to_bmp_streamer.sv
// top level: command decode, chunk sequencer and output stage of the bmp streamer
`timescale 1ns / 1ps
`include "framebuffer_to_bmp_streamer_macros.svh"

// Streams a 1bpp BMP file built from a framebuffer held in an on-chip byte memory.
// A write command produces no output. A read command passes through the geometry,
// size and classify states; a header or past-end chunk then issues one byte per
// cycle while the receiver accepts; a pixel chunk first runs the serial divider
// to find the starting row and column, then computes the row base, then issues
// one byte per cycle from the memory's single read port while the receiver
// accepts. The memory has no reset; bytes not written before they are read come
// out undefined.
module framebuffer_to_bmp_streamer import fb2bmp_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  parameter int MAX_CHUNK   = MAX_CHUNK_DEF
) (
  input  logic             clk,
  input  logic             rst,
  fb2bmp_item_if.sink      items,
  fb2bmp_result_if.source  results,
  fb2bmp_cfg_if.sink       cfg
);

  localparam int          AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [19:0] STORE_LIMIT = 20'(STORE_BYTES);
  localparam logic [6:0]  LEN_MAX     = 7'(MAX_CHUNK);
  localparam logic [19:0] HDR_EXT     = {12'd0, HDR_BYTES};

  state_t state, state_next;
  mode_t  mode;

  logic [11:0] image_width, image_height;
  logic [19:0] offset_r;
  logic [6:0]  len_r;
  logic [11:0] w_r, ht_r;
  logic [8:0]  row_code, row_bmp;
  logic [19:0] fsize;
  logic [6:0]  count;
  logic [5:0]  hdr_pos;
  logic [8:0]  col;
  logic [11:0] file_row;
  logic [19:0] row_base;

  logic        b_valid;
  stage_meta_t b_meta;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_empty;

  // combinational datapath
  logic [11:0] w_clamp, h_clamp;
  logic [12:0] w_plus;
  logic [8:0]  rc_calc;
  logic [9:0]  rb_plus;
  logic [8:0]  rb_calc;
  logic [20:0] size_prod;
  logic [19:0] byte_limit;
  logic [19:0] avail;
  logic [6:0]  count_calc;
  logic        past_end, in_header;
  logic [11:0] row_from_top;
  logic [20:0] base_prod;
  logic [19:0] fb_addr;
  logic        in_store, col_data;
  logic [6:0]  len_in;
  logic [19:0] wr_ext;

  logic        item_accept;
  logic        issue;
  logic        b_adv;
  logic        div_start;
  logic        div_done;
  logic [19:0] div_quot;
  logic [8:0]  div_rem;
  logic        wr_en;
  logic        rd_en;
  logic [7:0]  rd_data;

  assign w_clamp = (image_width == 12'd0) ? 12'd1 :
                   (image_width > MAX_DIM) ? MAX_DIM : image_width;
  assign h_clamp = (image_height == 12'd0) ? 12'd1 :
                   (image_height > MAX_DIM) ? MAX_DIM : image_height;
  assign w_plus  = {1'b0, w_clamp} + 13'd7;
  assign rc_calc = w_plus[11:3];
  assign rb_plus = {1'b0, rc_calc} + 10'd3;
  assign rb_calc = {rb_plus[8:2], 2'b00};

  assign size_prod = 21'(row_bmp) * 21'(ht_r);

  assign past_end   = offset_r >= fsize;
  assign in_header  = offset_r < HDR_EXT;
  assign byte_limit = in_header ? HDR_EXT : fsize;
  assign avail      = byte_limit - offset_r;
  assign count_calc = (avail < {13'd0, len_r}) ? avail[6:0] : len_r;

  assign row_from_top = ht_r - 12'd1 - file_row;
  assign base_prod    = 21'(row_from_top) * 21'(row_code);

  assign fb_addr  = row_base + {11'd0, col};
  assign in_store = fb_addr < STORE_LIMIT;
  assign col_data = col < row_code;

  assign len_in = (items.chunk_length == 7'd0) ? 7'd1 :
                  (items.chunk_length > LEN_MAX) ? LEN_MAX : items.chunk_length;
  assign wr_ext = {5'd0, items.store_address};

  assign item_accept = items.valid && items.ready;
  assign b_adv       = b_valid && (!out_valid || results.ready);
  assign wr_en       = item_accept && (items.command == CMD_WRITE) && (wr_ext < STORE_LIMIT);
  assign rd_en       = issue && (mode == MODE_PIXEL) && col_data && in_store;

  assign cfg.ready = 1'b1;

  assign results.valid         = out_valid;
  assign results.file_byte     = out_byte;
  assign results.last_of_chunk = out_last;
  assign results.chunk_empty   = out_empty;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    items.ready = 1'b0;
    issue       = 1'b0;
    div_start   = 1'b0;
    case (state)
      S_IDLE: begin
        items.ready = 1'b1;
        if (items.valid && items.command == CMD_READ) begin
          state_next = S_GEOM;
        end
      end
      S_GEOM:  state_next = S_SIZE;
      S_SIZE:  state_next = S_CLASS;
      S_CLASS: begin
        if (past_end || in_header) begin
          state_next = S_STREAM;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_BASE;
        end
      end
      S_BASE: state_next = S_STREAM;
      S_STREAM: begin
        issue = !b_valid || b_adv;
        if (issue && count == 7'd1) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg.data;
        CFG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // chunk datapath
  always_ff @(posedge clk) begin
    if (item_accept) begin
      offset_r <= items.file_offset;
      len_r    <= len_in;
    end
    case (state)
      S_GEOM: begin
        w_r      <= w_clamp;
        ht_r     <= h_clamp;
        row_code <= rc_calc;
        row_bmp  <= rb_calc;
      end
      S_SIZE: begin
        fsize <= size_prod[19:0] + HDR_EXT;
      end
      S_CLASS: begin
        hdr_pos <= offset_r[5:0];
        if (past_end) begin
          mode  <= MODE_EMPTY;
          count <= 7'd1;
        end else if (in_header) begin
          mode  <= MODE_HEADER;
          count <= count_calc;
        end else begin
          mode  <= MODE_PIXEL;
          count <= count_calc;
        end
      end
      S_DIV: begin
        if (div_done) begin
          file_row <= div_quot[11:0];
          col      <= div_rem;
        end
      end
      S_BASE: begin
        row_base <= base_prod[19:0];
      end
      S_STREAM: begin
        if (issue) begin
          count   <= count - 7'd1;
          hdr_pos <= hdr_pos + 6'd1;
          if (col + 9'd1 == row_bmp) begin
            col      <= '0;
            row_base <= row_base - {11'd0, row_code};
          end else begin
            col <= col + 9'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // read stage: meta waits alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (issue) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_meta.fixed_byte <= (mode == MODE_HEADER) ?
                           header_byte(hdr_pos, w_r, ht_r, fsize) : 8'h00;
      b_meta.use_mem    <= (mode == MODE_PIXEL) && col_data && in_store;
      b_meta.last       <= count == 7'd1;
      b_meta.empty      <= mode == MODE_EMPTY;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_byte  <= b_meta.use_mem ? rd_data : b_meta.fixed_byte;
      out_last  <= b_meta.last;
      out_empty <= b_meta.empty;
    end
  end

  fb2bmp_mem #(
    .DEPTH(STORE_BYTES),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_ext[AW-1:0]),
    .wr_data(items.store_data),
    .rd_en  (rd_en),
    .rd_addr(fb_addr[AW-1:0]),
    .rd_data(rd_data)
  );

  fb2bmp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset_r - HDR_EXT),
    .divisor  (row_bmp),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  `FB2BMP_ASSERT_IMP(a_read_only_streaming, rd_en, state == S_STREAM && mode == MODE_PIXEL)
  `FB2BMP_ASSERT_IMP(a_div_done_in_div, div_done, state == S_DIV)
  `FB2BMP_ASSERT_IMP(a_stream_count_live, state == S_STREAM, count != 7'd0)
  `FB2BMP_ASSERT_IMP(a_empty_is_last, out_valid && out_empty, out_last)
  `FB2BMP_ASSERT_NXT(a_read_feeds_stage, rd_en, b_valid && b_meta.use_mem)

endmodule

FILE: sv/fb2bmp_mem.sv
// framebuffer byte store, one write port and one registered read port
`timescale 1ns / 1ps

module fb2bmp_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/fb2bmp_div.sv
// radix-2 restoring divider, splits a pixel offset into row and column
`timescale 1ns / 1ps

module fb2bmp_div import fb2bmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [19:0] dividend,
  input  logic [8:0]  divisor,
  output logic        done,
  output logic [19:0] quotient,
  output logic [8:0]  remainder
);

  localparam int STEPS = 20;

  logic       busy;
  logic [4:0] step;
  logic [9:0] trial;
  logic [9:0] diff;
  logic       fits;

  assign trial = {remainder, quotient[19]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of the top of quotient while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[18:0], fits};
      remainder <= fits ? diff[8:0] : trial[8:0];
    end
  end

endmodule

FILE: dv/bmp_stream_checker.sv
// checker for the bmp streamer: mirrors the framebuffer and config, predicts and compares file bytes
`timescale 1ns / 1ps

module bmp_stream_checker import fb2bmp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  fb2bmp_item_if   items,
  fb2bmp_result_if results,
  fb2bmp_cfg_if    cfg,
  output int       bytes_due,
  output int       fail_count
);

  localparam int unsigned HDR_LEN = HDR_BYTES;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last_of_chunk;
    logic       chunk_empty;
  } chunk_byte_t;

  logic [7:0]  frame_copy [STORE_BYTES_DEF];
  logic [11:0] image_w;
  logic [11:0] image_h;
  chunk_byte_t expected_bytes [$];
  int          byte_seq;

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic int unsigned dim_clamp(input logic [11:0] v);
    if (v == 12'd0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic last, input logic empty);
    chunk_byte_t e;
    e.file_byte     = b;
    e.last_of_chunk = last;
    e.chunk_empty   = empty;
    expected_bytes.push_back(e);
  endfunction

  // work out every byte that one read command emits
  function automatic void predict_chunk(input logic [19:0] offset, input logic [6:0] len_field);
    int unsigned w, ht, rc, rb, fs, len, stop, pos, p, row, col, fb;
    logic [7:0]  hdr [HDR_LEN];
    logic [7:0]  b;
    w  = dim_clamp(image_w);
    ht = dim_clamp(image_h);
    rc = (w + 7) / 8;
    rb = (rc + 3) & ~32'd3;
    fs = HDR_LEN + rb * ht;
    len = len_field;
    if (len < 1) len = 1;
    if (len > MAX_CHUNK_DEF) len = MAX_CHUNK_DEF;
    if (offset >= fs) begin
      push_byte(8'h00, 1'b1, 1'b1);
      return;
    end
    if (offset < HDR_LEN) begin
      foreach (hdr[k]) hdr[k] = 8'h00;
      hdr[0] = BMP_MAGIC[7:0];
      hdr[1] = BMP_MAGIC[15:8];
      for (int k = 0; k < 4; k++) begin
        hdr[2 + k]  = 8'(fs >> (8 * k));
        hdr[18 + k] = 8'(w >> (8 * k));
        hdr[22 + k] = 8'(ht >> (8 * k));
      end
      hdr[10] = HDR_BYTES;
      hdr[14] = INFO_BYTES;
      hdr[26] = PLANES;
      hdr[28] = BIT_DEPTH;
      hdr[35] = IMG_SIZE_TAG;
      hdr[58] = PAL_WHITE;
      hdr[59] = PAL_WHITE;
      hdr[60] = PAL_WHITE;
      // a header chunk never runs on into pixel data
      stop = offset + len;
      if (stop > HDR_LEN) stop = HDR_LEN;
      for (pos = offset; pos < stop; pos++) push_byte(hdr[pos], pos + 1 == stop, 1'b0);
      return;
    end
    stop = offset + len;
    if (stop > fs) stop = fs;
    for (pos = offset; pos < stop; pos++) begin
      p   = pos - HDR_LEN;
      row = p / rb;
      col = p - row * rb;
      b   = 8'h00;
      // rows go bottom-up; pad bytes and bytes beyond the store read as zero
      if (col < rc && row < ht) begin
        fb = (ht - 1 - row) * rc + col;
        if (fb < STORE_BYTES_DEF) b = frame_copy[fb];
      end
      push_byte(b, pos + 1 == stop, 1'b0);
    end
  endfunction

  always @(posedge clk) begin
    chunk_byte_t e;
    if (rst) begin
      image_w = WIDTH_RESET;
      image_h = HEIGHT_RESET;
      expected_bytes.delete();
      byte_seq = 0;
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_IMAGE_WIDTH:  image_w = cfg.data;
          CFG_IMAGE_HEIGHT: image_h = cfg.data;
          default: ;
        endcase
      end
      if (items.valid && items.ready) begin
        if (items.command == CMD_WRITE) frame_copy[items.store_address] = items.store_data;
        else predict_chunk(items.file_offset, items.chunk_length);
      end
      if (results.valid && results.ready) begin
        if (expected_bytes.size() == 0) begin
          flag_mismatch($sformatf("byte %0d: unexpected transaction, file_byte %02h",
                                  byte_seq, results.file_byte));
        end else begin
          e = expected_bytes.pop_front();
          if (results.file_byte !== e.file_byte)
            flag_mismatch($sformatf("byte %0d: file_byte %02h, expected %02h",
                                    byte_seq, results.file_byte, e.file_byte));
          if (results.last_of_chunk !== e.last_of_chunk)
            flag_mismatch($sformatf("byte %0d: last_of_chunk %b, expected %b",
                                    byte_seq, results.last_of_chunk, e.last_of_chunk));
          if (results.chunk_empty !== e.chunk_empty)
            flag_mismatch($sformatf("byte %0d: chunk_empty %b, expected %b",
                                    byte_seq, results.chunk_empty, e.chunk_empty));
        end
        byte_seq++;
      end
    end
    bytes_due = expected_bytes.size();
  end

endmodule

FILE: dv/tb_framebuffer_to_bmp_streamer.sv
// testbench top for the bmp streamer: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_framebuffer_to_bmp_streamer;
  import fb2bmp_pkg::*;

  localparam int unsigned HDR_LEN = HDR_BYTES;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int QUIET_LIMIT   = 3000;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 4'd15;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   bytes_due;
  int   fail_count;
  int   quiet_cycles = 0;
  bit   steady = 1'b0;
  bit   stall_request = 1'b0;
  bit   written [STORE_BYTES_DEF];
  logic [11:0] cur_w = WIDTH_RESET;
  logic [11:0] cur_h = HEIGHT_RESET;

  fb2bmp_item_if   item_ch ();
  fb2bmp_result_if byte_ch ();
  fb2bmp_cfg_if    cfg_ch ();

  framebuffer_to_bmp_streamer dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (byte_ch),
    .cfg     (cfg_ch)
  );

  bmp_stream_checker chk (
    .clk        (clk),
    .rst        (rst),
    .items      (item_ch),
    .results    (byte_ch),
    .cfg        (cfg_ch),
    .bytes_due  (bytes_due),
    .fail_count (fail_count)
  );

  always #2 clk = ~clk;

  function automatic int unsigned dim_clamp(input logic [11:0] v);
    if (v == 12'd0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic void geometry(output int unsigned rc, output int unsigned rb,
                                   output int unsigned ht, output int unsigned fs);
    int unsigned w;
    w  = dim_clamp(cur_w);
    ht = dim_clamp(cur_h);
    rc = (w + 7) / 8;
    rb = (rc + 3) & ~32'd3;
    fs = HDR_LEN + rb * ht;
  endfunction

  function automatic int sender_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [19:0] pick_offset(input int unsigned fs);
    int r;
    int unsigned lo;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, HDR_LEN - 1);
    if (r < 20) return $urandom_range(HDR_LEN - 6, HDR_LEN + 3);
    if (r < 32) begin
      lo = (fs > HDR_LEN + 70) ? fs - 70 : HDR_LEN;
      return $urandom_range(lo, fs - 1);
    end
    if (r < 42) return $urandom_range(fs, 20'hFFFFF);
    return $urandom_range(HDR_LEN, fs - 1);
  endfunction

  function automatic logic [6:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 7'd0;
    if (r < 16) return $urandom_range(MAX_CHUNK_DEF + 1, 127);
    if (r < 30) return MAX_CHUNK_DEF;
    return $urandom_range(1, MAX_CHUNK_DEF - 1);
  endfunction

  // one transaction on the command channel, entered and left at a falling edge
  task automatic push_item(input logic cmd, input logic [14:0] addr, input logic [7:0] data,
                           input logic [19:0] off, input logic [6:0] len);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid         = 1'b1;
    item_ch.command       = cmd;
    item_ch.store_address = addr;
    item_ch.store_data    = data;
    item_ch.file_offset   = off;
    item_ch.chunk_length  = len;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_write(input logic [14:0] addr, input logic [7:0] data);
    push_item(CMD_WRITE, addr, data, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 127));
    written[addr] = 1'b1;
  endtask

  // write every framebuffer byte the read will touch that holds no data yet
  task automatic ensure_rows(input int unsigned off, input int unsigned len);
    int unsigned rc, rb, ht, fs, stop, pos, p, row, col, fb;
    geometry(rc, rb, ht, fs);
    if (len < 1) len = 1;
    if (len > MAX_CHUNK_DEF) len = MAX_CHUNK_DEF;
    if (off < HDR_LEN || off >= fs) return;
    stop = off + len;
    if (stop > fs) stop = fs;
    for (pos = off; pos < stop; pos++) begin
      p   = pos - HDR_LEN;
      row = p / rb;
      col = p - row * rb;
      if (col < rc && row < ht) begin
        fb = (ht - 1 - row) * rc + col;
        if (fb < STORE_BYTES_DEF && !written[fb]) send_write(fb[14:0], $urandom_range(0, 255));
      end
    end
  endtask

  task automatic send_read(input logic [19:0] off, input logic [6:0] len);
    ensure_rows(off, len);
    push_item(CMD_READ, $urandom_range(0, STORE_BYTES_DEF - 1), $urandom_range(0, 255), off, len);
  endtask

  task automatic random_item();
    int unsigned rc, rb, ht, fs;
    geometry(rc, rb, ht, fs);
    if ($urandom_range(0, 99) < 25)
      send_write($urandom_range(0, STORE_BYTES_DEF - 1), $urandom_range(0, 255));
    else
      send_read(pick_offset(fs), pick_length());
  endtask

  task automatic wait_drained();
    item_ch.valid = 1'b0;
    while (bytes_due != 0) @(negedge clk);
  endtask

  // a write leaves no result behind, so give the block time to finish after the last byte
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [11:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx == CFG_IMAGE_WIDTH) cur_w = value;
    else if (idx == CFG_IMAGE_HEIGHT) cur_h = value;
  endtask

  task automatic run_phase(input logic [11:0] w, input logic [11:0] h, input int count);
    settle();
    write_register(CFG_IMAGE_WIDTH, w);
    write_register(CFG_IMAGE_HEIGHT, h);
    steady = ($urandom_range(0, 3) == 0);
    repeat (count) random_item();
  endtask

  // receiver: random stretches of ready, plus one long hold-off on request
  initial begin
    int stretch;
    byte_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_request) begin
        byte_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        stall_request = 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            byte_ch.ready = 1'b1;
            stretch = $urandom_range(10, 60);
          end
          2: begin
            byte_ch.ready = ($urandom_range(0, 3) == 0);
            stretch = byte_ch.ready ? 1 : $urandom_range(15, 50);
          end
          default: begin
            byte_ch.ready = ($urandom_range(0, 3) != 0);
            stretch = $urandom_range(1, 3);
          end
        endcase
        repeat (stretch) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (byte_ch.valid && byte_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned rc, rb, ht, fs;
    item_ch.valid         = 1'b0;
    item_ch.command       = CMD_WRITE;
    item_ch.store_address = '0;
    item_ch.store_data    = '0;
    item_ch.file_offset   = '0;
    item_ch.chunk_length  = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = CFG_IMAGE_WIDTH;
    cfg_ch.data           = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset geometry, header edges, length limits, file end, past end
    geometry(rc, rb, ht, fs);
    send_write(15'h7FFF, 8'hFF);
    send_write(15'h0000, 8'h00);
    send_read(20'd0, 7'd64);
    send_read(20'd0, 7'd0);
    send_read(20'd30, 7'd127);
    send_read(HDR_LEN - 1, 7'd1);
    send_read(HDR_LEN - 4, 7'd10);
    send_read(HDR_LEN, 7'd64);
    send_read(fs - 10, 7'd64);
    send_read(fs - 1, 7'd1);
    send_read(fs, 7'd1);
    send_read(20'hFFFFF, 7'd127);
    send_read(fs - ht * 0 - rb, 7'd64);
    send_read(fs - rb, 7'd100);

    // fill the block while the receiver holds off, then let it drain
    stall_request = 1'b1;
    steady = 1'b1;
    repeat (20) send_read($urandom_range(HDR_LEN, fs - 1), 7'd64);
    wait_drained();
    steady = 1'b0;

    run_phase(12'd1, 12'd1, 40);
    run_phase(12'd2048, 12'd2048, 45);
    run_phase(12'd0, 12'd4095, 35);
    run_phase(12'd4095, 12'd0, 30);
    run_phase(12'd13, 12'd7, 35);
    settle();
    write_register(CFG_SPARE_INDEX, $urandom_range(0, 4095));
    run_phase($urandom_range(1, 2048), $urandom_range(1, 48), 45);
    run_phase($urandom_range(1, 2048), $urandom_range(1, 48), 45);
    run_phase($urandom_range(1, 256), $urandom_range(1, 2048), 45);
    run_phase($urandom_range(1, 2048), $urandom_range(1, 48), 45);
    run_phase($urandom_range(1, 64), $urandom_range(1, 16), 45);
    settle();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/fb2bmp_pkg.sv
sv/fb2bmp_ifs.sv
sv/fb2bmp_mem.sv
sv/fb2bmp_div.sv
sv/framebuffer_to_bmp_streamer.sv
dv/bmp_stream_checker.sv
dv/tb_framebuffer_to_bmp_streamer.sv
